@@ src/ras_pkg.sv @@
// Package for the rectangular assignment solver.
// Sizes, status and config codes, state and store types; no dependencies.
package ras_pkg;
  localparam int MaxRows = 16;
  localparam int MaxCols = 16;
  localparam int StoreDepth = MaxRows * MaxCols;
  localparam int AddrW = $clog2(StoreDepth);
  localparam int CntW = 5;
  localparam int ColW = $clog2(MaxCols + 1);
  localparam int RowW = $clog2(MaxRows + 1);
  localparam int PotW = 48;
  localparam logic signed [PotW-1:0] SlackMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [PotW-1:0] ForbiddenCost = 48'sd1073741823;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StRowsExceed = 2'd1;
  localparam logic [1:0] StRowForbidden = 2'd2;
  localparam logic [1:0] StEdgeForbidden = 2'd3;

  localparam logic [1:0] CfgMaximize = 2'd0;
  localparam logic [1:0] CfgRows = 2'd1;
  localparam logic [1:0] CfgCols = 2'd2;

  typedef enum logic [4:0] {
    S_LOAD, S_CHECK_RD, S_CHECK, S_ROW_INIT, S_INIT_COL, S_SCAN_RD, S_SCAN,
    S_UPDATE, S_AUG, S_MATCH, S_VER_RD, S_VER, S_EMIT_RD, S_EMIT, S_OUT
  } state_t;

  // Store access request between the sequencer and the matrix memory.
  typedef struct packed {
    logic             wr;
    logic [AddrW-1:0] addr;
    logic [31:0]      cost;
    logic             forbid;
  } store_req_t;

  typedef struct packed {
    logic [31:0] cost;
    logic        forbid;
  } store_rd_t;
endpackage

@@ src/ras_if.sv @@
// Valid/ready channel interfaces for input entries and results.
// Depends on nothing outside this file.
interface ras_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] cost_value;
  logic        forbidden;
  logic        last_entry;
  modport source(output valid, cost_value, forbidden, last_entry, input ready);
  modport sink(input valid, cost_value, forbidden, last_entry, output ready);
endinterface

interface ras_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  row_index;
  logic [3:0]  column_index;
  logic [47:0] running_total;
  logic [1:0]  status;
  logic        final_result;
  modport source(output valid, row_index, column_index, running_total, status,
                 final_result, input ready);
  modport sink(input valid, row_index, column_index, running_total, status,
               final_result, output ready);
endinterface

@@ src/ras_store.sv @@
// Cost matrix memory: one synchronous port; read data is registered and appears in the cycle after the address.
// Depends on ras_pkg.
module ras_store (
  input  logic                clk,
  input  ras_pkg::store_req_t req,
  output ras_pkg::store_rd_t  rd
);
  logic [31:0] cost_mem [ras_pkg::StoreDepth];
  logic        forbid_mem [ras_pkg::StoreDepth];

  // Write one entry when requested, and read one entry every cycle.
  always_ff @(posedge clk) begin
    if (req.wr) begin
      cost_mem[req.addr] <= req.cost;
      forbid_mem[req.addr] <= req.forbid;
    end
    rd.cost <= cost_mem[req.addr];
    rd.forbid <= forbid_mem[req.addr];
  end
endmodule

@@ src/rectangular_assignment_solver.sv @@
// Rectangular assignment solver: Hungarian method with potentials.
// Loading stores each accepted entry in the matrix memory. After the last entry the row check
// reads each entry in a read state and a check state, and each search step scans the columns.
// Each row is then verified (read, check) and reported (read, emit, output) when the output is ready.
// Reset is synchronous; it clears control state and configuration only.
module rectangular_assignment_solver (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [4:0]                cfg_data,
  ras_in_if.sink                    in_ch,
  ras_out_if.source                 out_ch
);
  localparam int CW = ras_pkg::ColW;
  localparam int PW = ras_pkg::PotW;

  ras_pkg::state_t state, state_next;

  logic       maximize;
  logic [4:0] rows_cfg, cols_cfg;
  logic [ras_pkg::AddrW-1:0] load_cnt;
  logic [CW-1:0] n, m;

  // Small per-row and per-column state, addressed by row or column.
  logic signed [PW-1:0] upot [ras_pkg::MaxRows+1];
  logic signed [PW-1:0] vpot [ras_pkg::MaxCols+1];
  logic signed [PW-1:0] slack [ras_pkg::MaxCols+1];
  logic [CW-1:0] owner [ras_pkg::MaxCols+1];
  logic [CW-1:0] link [ras_pkg::MaxCols+1];
  logic [ras_pkg::MaxCols:0] visited;

  logic [CW-1:0] row_i, col_j, cur, nxt, own;
  logic signed [PW-1:0] delta;
  logic any_ok;
  logic signed [PW-1:0] total;
  logic [3:0] match_col [ras_pkg::MaxRows];

  ras_pkg::store_req_t req;
  ras_pkg::store_rd_t  rd;

  ras_store u_store (.clk(clk), .req(req), .rd(rd));

  // Clamped counts.
  assign n = (rows_cfg > 5'(ras_pkg::MaxRows)) ? CW'(ras_pkg::MaxRows) : CW'(rows_cfg);
  assign m = (cols_cfg > 5'(ras_pkg::MaxCols)) ? CW'(ras_pkg::MaxCols) : CW'(cols_cfg);

  logic [ras_pkg::AddrW-1:0] rd_addr;
  logic [CW-1:0] rrow;
  logic [3:0] rcol;
  // Row-major address of (rrow, rcol).
  assign rd_addr = ras_pkg::AddrW'(rrow * m + rcol);

  always_comb begin
    rrow = row_i;
    rcol = 4'(col_j - 1'b1);
    case (state)
      ras_pkg::S_CHECK_RD, ras_pkg::S_CHECK: rcol = 4'(col_j);
      ras_pkg::S_SCAN_RD, ras_pkg::S_SCAN: begin
        rrow = own - 1'b1;
        rcol = 4'(col_j - 1'b1);
      end
      ras_pkg::S_VER_RD, ras_pkg::S_VER, ras_pkg::S_EMIT_RD, ras_pkg::S_EMIT:
        rcol = match_col[4'(row_i)];
      default: ;
    endcase
  end

  always_comb begin
    req.wr = (state == ras_pkg::S_LOAD) && in_ch.valid;
    req.addr = (state == ras_pkg::S_LOAD) ? load_cnt : rd_addr;
    req.cost = in_ch.cost_value;
    req.forbid = in_ch.forbidden;
  end

  assign in_ch.ready = (state == ras_pkg::S_LOAD);

  // Working cost of the entry just read.
  logic signed [PW-1:0] wcost, reduced;
  always_comb begin
    if (rd.forbid) wcost = ras_pkg::ForbiddenCost;
    else if (maximize) wcost = -PW'(signed'(rd.cost));
    else wcost = PW'(signed'(rd.cost));
    reduced = wcost - upot[own] - vpot[col_j];
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ras_pkg::S_LOAD:
        if (in_ch.valid && in_ch.last_entry) begin
          if (n == 0 || n > m) state_next = ras_pkg::S_OUT;
          else state_next = ras_pkg::S_CHECK_RD;
        end
      ras_pkg::S_CHECK_RD: state_next = ras_pkg::S_CHECK;
      ras_pkg::S_CHECK:
        if (col_j == m - 1'b1) begin
          if (!(any_ok || !rd.forbid)) state_next = ras_pkg::S_OUT;
          else if (row_i == n - 1'b1) state_next = ras_pkg::S_ROW_INIT;
          else state_next = ras_pkg::S_CHECK_RD;
        end else state_next = ras_pkg::S_CHECK_RD;
      ras_pkg::S_ROW_INIT: state_next = ras_pkg::S_INIT_COL;
      ras_pkg::S_INIT_COL: state_next = ras_pkg::S_SCAN_RD;
      ras_pkg::S_SCAN_RD:
        state_next = visited[col_j] ? ((col_j == m) ? ras_pkg::S_UPDATE
                                                    : ras_pkg::S_SCAN_RD)
                                    : ras_pkg::S_SCAN;
      ras_pkg::S_SCAN:
        state_next = (col_j == m) ? ras_pkg::S_UPDATE : ras_pkg::S_SCAN_RD;
      ras_pkg::S_UPDATE:
        state_next = (owner[nxt] == '0) ? ras_pkg::S_AUG : ras_pkg::S_INIT_COL;
      ras_pkg::S_AUG:
        if (link[cur] == '0)
          state_next = (row_i == n) ? ras_pkg::S_MATCH : ras_pkg::S_ROW_INIT;
      ras_pkg::S_MATCH: state_next = ras_pkg::S_VER_RD;
      ras_pkg::S_VER_RD: state_next = ras_pkg::S_VER;
      ras_pkg::S_VER:
        if (rd.forbid) state_next = ras_pkg::S_OUT;
        else if (row_i == n - 1'b1) state_next = ras_pkg::S_EMIT_RD;
        else state_next = ras_pkg::S_VER_RD;
      ras_pkg::S_EMIT_RD: state_next = ras_pkg::S_EMIT;
      ras_pkg::S_EMIT: state_next = ras_pkg::S_OUT;
      ras_pkg::S_OUT:
        if (out_ch.ready)
          state_next = out_ch.final_result ? ras_pkg::S_LOAD : ras_pkg::S_EMIT_RD;
      default: state_next = ras_pkg::S_LOAD;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      maximize <= 1'b0;
      rows_cfg <= '0;
      cols_cfg <= 5'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        ras_pkg::CfgMaximize: maximize <= cfg_data[0];
        ras_pkg::CfgRows: rows_cfg <= cfg_data;
        ras_pkg::CfgCols: cols_cfg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ras_pkg::S_LOAD;
    else state <= state_next;
  end

  logic out_valid;
  assign out_ch.valid = out_valid;

  // Datapath of the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ras_pkg::S_LOAD: begin
          if (in_ch.valid) begin
            load_cnt <= in_ch.last_entry ? '0 : load_cnt + 1'b1;
            if (in_ch.last_entry) begin
              row_i <= '0;
              col_j <= '0;
              any_ok <= 1'b0;
              out_ch.row_index <= '0;
              out_ch.column_index <= '0;
              out_ch.running_total <= '0;
              out_ch.final_result <= 1'b1;
              out_ch.status <= (n == 0) ? ras_pkg::StOk : ras_pkg::StRowsExceed;
              out_valid <= (n == 0 || n > m);
              for (int k = 0; k <= ras_pkg::MaxRows; k++) upot[k] <= '0;
              for (int k = 0; k <= ras_pkg::MaxCols; k++) begin
                vpot[k] <= '0;
                owner[k] <= '0;
                link[k] <= '0;
              end
            end
          end
        end
        ras_pkg::S_CHECK: begin
          if (col_j == m - 1'b1) begin
            if (!(any_ok || !rd.forbid)) begin
              out_ch.row_index <= 4'(row_i);
              out_ch.status <= ras_pkg::StRowForbidden;
              out_valid <= 1'b1;
            end
            row_i <= (row_i == n - 1'b1) ? CW'(1) : row_i + 1'b1;
            col_j <= '0;
            any_ok <= 1'b0;
          end else begin
            col_j <= col_j + 1'b1;
            any_ok <= any_ok || !rd.forbid;
          end
        end
        ras_pkg::S_ROW_INIT: begin
          owner[0] <= row_i;
          cur <= '0;
          link[0] <= '0;
          visited <= '0;
          for (int k = 0; k <= ras_pkg::MaxCols; k++) slack[k] <= ras_pkg::SlackMax;
        end
        ras_pkg::S_INIT_COL: begin
          visited[cur] <= 1'b1;
          own <= owner[cur];
          delta <= ras_pkg::SlackMax;
          nxt <= '0;
          col_j <= CW'(1);
        end
        ras_pkg::S_SCAN_RD: begin
          if (visited[col_j]) col_j <= col_j + 1'b1;
        end
        ras_pkg::S_SCAN: begin
          if (reduced < slack[col_j]) begin
            slack[col_j] <= reduced;
            link[col_j] <= cur;
            if (reduced < delta) begin
              delta <= reduced;
              nxt <= col_j;
            end
          end else if (slack[col_j] < delta) begin
            delta <= slack[col_j];
            nxt <= col_j;
          end
          col_j <= col_j + 1'b1;
        end
        ras_pkg::S_UPDATE: begin
          for (int k = 0; k <= ras_pkg::MaxCols; k++) begin
            if (k <= m) begin
              if (visited[k]) begin
                upot[owner[k]] <= upot[owner[k]] + delta;
                vpot[k] <= vpot[k] - delta;
              end else slack[k] <= slack[k] - delta;
            end
          end
          cur <= nxt;
        end
        ras_pkg::S_AUG: begin
          owner[cur] <= owner[link[cur]];
          cur <= link[cur];
          if (link[cur] == '0) row_i <= row_i + 1'b1;
        end
        ras_pkg::S_MATCH: begin
          for (int k = 0; k < ras_pkg::MaxRows; k++) match_col[k] <= '0;
          for (int k = 1; k <= ras_pkg::MaxCols; k++)
            if (k <= m && owner[k] != '0 && owner[k] <= n)
              match_col[4'(owner[k] - 1'b1)] <= 4'(k - 1);
          row_i <= '0;
        end
        ras_pkg::S_VER: begin
          if (rd.forbid) begin
            out_ch.row_index <= 4'(row_i);
            out_ch.column_index <= match_col[4'(row_i)];
            out_ch.status <= ras_pkg::StEdgeForbidden;
            out_valid <= 1'b1;
          end else if (row_i == n - 1'b1) begin
            row_i <= '0;
            total <= '0;
          end else row_i <= row_i + 1'b1;
        end
        ras_pkg::S_EMIT: begin
          total <= total + PW'(signed'(rd.cost));
          out_ch.row_index <= 4'(row_i);
          out_ch.column_index <= match_col[4'(row_i)];
          out_ch.running_total <= total + PW'(signed'(rd.cost));
          out_ch.status <= ras_pkg::StOk;
          out_ch.final_result <= (row_i == n - 1'b1);
          out_valid <= 1'b1;
          row_i <= row_i + 1'b1;
        end
        ras_pkg::S_OUT: if (out_ch.ready) out_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  // A result is only offered in the output state.
  a_valid_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == ras_pkg::S_OUT) else $error("result outside output state");
  // Loading is never accepted while a result is pending.
  a_no_load: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_valid) else $error("input ready with pending result");
  // After the final result is taken the block returns to loading.
  a_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ch.ready && out_ch.final_result |=> state == ras_pkg::S_LOAD)
    else $error("did not return to load");
endmodule

@@ tb/tb_rectangular_assignment_solver.sv @@
// Self-checking testbench for the rectangular assignment solver.
// Depends on ras_pkg (src/ras_pkg.sv), the channel interfaces (src/ras_if.sv) and the top module.
// A local Hungarian-method predictor checks every result transaction in order.
module tb_rectangular_assignment_solver;
  localparam int CycleLimit = 20000000;
  localparam int SettleCycles = 60;
  localparam int LongHold = 400;
  localparam longint SlackCeil = 64'h0000_7FFF_FFFF_FFFF;
  localparam longint BlockedCost = 64'd1073741823;

  typedef struct packed {
    logic [31:0] cost;
    logic        forbid;
    logic        last;
  } entry_t;

  typedef struct packed {
    logic [3:0]  row;
    logic [3:0]  col;
    logic [47:0] total;
    logic [1:0]  status;
    logic        fin;
  } match_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [1:0] cfg_index;
  logic [4:0] cfg_data;

  ras_in_if in_ch();
  ras_out_if out_ch();

  rectangular_assignment_solver dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Entries waiting to be offered, and assignments still to arrive.
  entry_t entry_queue[$];
  match_t pending_matches[$];

  // Shadow of the configuration and of the matrix memory.
  bit mirror_max;
  int mirror_rows;
  int mirror_cols;
  logic [31:0] mat_cost[ras_pkg::StoreDepth];
  bit mat_forbid[ras_pkg::StoreDepth];
  int fill_ptr;

  // Working arrays of the potential-based solve.
  longint pot_row[ras_pkg::MaxRows + 1];
  longint pot_col[ras_pkg::MaxCols + 1];
  int col_owner[ras_pkg::MaxCols + 1];
  int col_link[ras_pkg::MaxCols + 1];
  longint col_slack[ras_pkg::MaxCols + 1];
  bit col_seen[ras_pkg::MaxCols + 1];

  int mismatches;
  int entries_queued;
  int cycle_count;
  bit quiet;
  bit in_taken;
  int in_gap;
  int out_gap;
  int hold_req;
  int hold_seen;
  int hold_left;

  // Clock generation.
  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint edge_weight(int idx);
    longint c;
    if (mat_forbid[idx]) return BlockedCost;
    c = longint'($signed(mat_cost[idx]));
    return mirror_max ? -c : c;
  endfunction

  function automatic void push_match(int row, int col, longint total, logic [1:0] status,
                                     bit fin);
    match_t r;
    r.row = row[3:0];
    r.col = col[3:0];
    r.total = total[47:0];
    r.status = status;
    r.fin = fin;
    pending_matches.push_back(r);
  endfunction

  // Shortest augmenting path search with row and column potentials.
  function automatic void run_hungarian(int n, int m);
    int i, j, cur, nxt, w, prev;
    longint delta, red;
    for (j = 0; j <= ras_pkg::MaxCols; j++) begin
      pot_col[j] = 0;
      col_owner[j] = 0;
      col_link[j] = 0;
    end
    for (j = 0; j <= ras_pkg::MaxRows; j++) pot_row[j] = 0;
    for (i = 1; i <= n; i++) begin
      cur = 0;
      col_owner[0] = i;
      for (j = 0; j <= m; j++) begin
        col_slack[j] = SlackCeil;
        col_seen[j] = 1'b0;
      end
      col_link[0] = 0;
      do begin
        col_seen[cur] = 1'b1;
        w = col_owner[cur];
        delta = SlackCeil;
        nxt = 0;
        for (j = 1; j <= m; j++) begin
          if (!col_seen[j]) begin
            red = edge_weight(((w - 1) * m + j - 1) % ras_pkg::StoreDepth)
                  - pot_row[w] - pot_col[j];
            if (red < col_slack[j]) begin
              col_slack[j] = red;
              col_link[j] = cur;
            end
            if (col_slack[j] < delta) begin
              delta = col_slack[j];
              nxt = j;
            end
          end
        end
        for (j = 0; j <= m; j++) begin
          if (col_seen[j]) begin
            pot_row[col_owner[j]] += delta;
            pot_col[j] -= delta;
          end else begin
            col_slack[j] -= delta;
          end
        end
        cur = nxt;
      end while (col_owner[cur] != 0);
      do begin
        prev = col_link[cur];
        col_owner[cur] = col_owner[prev];
        cur = prev;
      end while (cur != 0);
    end
  endfunction

  // Store one accepted entry and, on the last one, predict the assignment.
  function automatic void absorb_entry(entry_t e);
    int n, m, i, j, r;
    int pick[ras_pkg::MaxRows];
    longint sum;
    bit any;
    mat_cost[fill_ptr] = e.cost;
    mat_forbid[fill_ptr] = e.forbid;
    fill_ptr = (fill_ptr + 1) % ras_pkg::StoreDepth;
    if (!e.last) return;
    fill_ptr = 0;
    n = (mirror_rows > ras_pkg::MaxRows) ? ras_pkg::MaxRows : mirror_rows;
    m = (mirror_cols > ras_pkg::MaxCols) ? ras_pkg::MaxCols : mirror_cols;
    if (n == 0) begin
      push_match(0, 0, 0, ras_pkg::StOk, 1'b1);
      return;
    end
    if (n > m) begin
      push_match(0, 0, 0, ras_pkg::StRowsExceed, 1'b1);
      return;
    end
    for (i = 0; i < n; i++) begin
      any = 1'b0;
      for (j = 0; j < m; j++)
        if (!mat_forbid[(i * m + j) % ras_pkg::StoreDepth]) any = 1'b1;
      if (!any) begin
        push_match(i, 0, 0, ras_pkg::StRowForbidden, 1'b1);
        return;
      end
    end
    run_hungarian(n, m);
    for (i = 0; i < ras_pkg::MaxRows; i++) pick[i] = 0;
    for (j = 1; j <= m; j++) begin
      r = col_owner[j];
      if (r != 0 && r <= n) pick[r - 1] = j - 1;
    end
    for (i = 0; i < n; i++) begin
      if (mat_forbid[(i * m + pick[i]) % ras_pkg::StoreDepth]) begin
        push_match(i, pick[i], 0, ras_pkg::StEdgeForbidden, 1'b1);
        return;
      end
    end
    sum = 0;
    for (i = 0; i < n; i++) begin
      sum += longint'($signed(mat_cost[(i * m + pick[i]) % ras_pkg::StoreDepth]));
      push_match(i, pick[i], sum, ras_pkg::StOk, (i + 1 == n));
    end
  endfunction

  function automatic void note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endfunction

  // Input side: offer queued entries at the falling edge, with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // Hold the offered transaction until it is taken.
    end else if (in_gap > 0) begin
      in_gap--;
      in_ch.valid <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      in_gap = $urandom_range(1, 19) - 1;
      in_ch.valid <= 1'b0;
    end else if (entry_queue.size() > 0) begin
      entry_t e;
      e = entry_queue.pop_front();
      in_ch.cost_value <= e.cost;
      in_ch.forbidden <= e.forbid;
      in_ch.last_entry <= e.last;
      in_ch.valid <= 1'b1;
    end else begin
      in_ch.valid <= 1'b0;
    end
    in_taken = 1'b0;
  end

  // Output side: random back-pressure, plus one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = LongHold - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(1, 19) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Input monitor: every accepted transaction goes to the predictor.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      entry_t e;
      e.cost = in_ch.cost_value;
      e.forbid = in_ch.forbidden;
      e.last = in_ch.last_entry;
      absorb_entry(e);
      in_taken = 1'b1;
    end
  end

  // Output monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      match_t want;
      if (pending_matches.size() == 0) begin
        note_mismatch($sformatf("unexpected result row %0d col %0d status %0d",
                                out_ch.row_index, out_ch.column_index, out_ch.status));
      end else begin
        want = pending_matches.pop_front();
        if (out_ch.row_index !== want.row || out_ch.column_index !== want.col ||
            out_ch.running_total !== want.total || out_ch.status !== want.status ||
            out_ch.final_result !== want.fin)
          note_mismatch($sformatf(
            "exp row %0d col %0d total %0d st %0d fin %0d, got %0d %0d %0d %0d %0d",
            want.row, want.col, $signed(want.total), want.status, want.fin,
            out_ch.row_index, out_ch.column_index, $signed(out_ch.running_total),
            out_ch.status, out_ch.final_result));
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_rectangular_assignment_solver: FAIL");
      $finish;
    end
  end

  task automatic add_entry(logic [31:0] cost, bit forbid, bit last);
    entry_t e;
    e.cost = cost;
    e.forbid = forbid;
    e.last = last;
    entry_queue.push_back(e);
    entries_queued++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Only called while the block is idle.
  task automatic set_config(bit mx, int n, int m);
    write_reg(ras_pkg::CfgMaximize, 5'(mx));
    write_reg(ras_pkg::CfgRows, 5'(n));
    write_reg(ras_pkg::CfgCols, 5'(m));
    mirror_max = mx;
    mirror_rows = n;
    mirror_cols = m;
  endtask

  // Wait until every entry is taken and every result has arrived.
  task automatic drain();
    while (entry_queue.size() != 0 || in_ch.valid || pending_matches.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Queue one matrix; a count below n*m ends the transaction stream early.
  task automatic queue_matrix(int count, int style, int forbid_odds);
    int k;
    logic [31:0] c;
    for (k = 0; k < count; k++) begin
      case (style)
        0: c = 32'($signed($urandom_range(0, 8)) - 4);
        1: c = 32'($signed($urandom_range(0, 2000)) - 1000);
        default: c = $urandom;
      endcase
      add_entry(c, forbid_odds != 0 && $urandom_range(1, forbid_odds) == 1, k == count - 1);
    end
  endtask

  initial begin
    int phase, nmat, k, n, m, roll, count;
    in_ch.valid = 1'b0;
    in_ch.cost_value = '0;
    in_ch.forbidden = 1'b0;
    in_ch.last_entry = 1'b0;
    out_ch.ready = 1'b0;
    cfg_write = 1'b0;
    cfg_index = ras_pkg::CfgMaximize;
    cfg_data = '0;
    rst = 1'b1;
    mirror_max = 1'b0;
    mirror_rows = 0;
    mirror_cols = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill the whole matrix memory once so no later solve reads an unwritten entry.
    for (k = 0; k < ras_pkg::StoreDepth; k++)
      add_entry($urandom, $urandom_range(0, 7) == 0, 1'b0);
    drain();

    // Zero rows, with one and with zero columns.
    set_config(1'b0, 0, 1);
    add_entry(32'd5, 1'b0, 1'b1);
    drain();
    set_config(1'b0, 0, 0);
    add_entry(32'd1, 1'b0, 1'b1);
    drain();

    // More rows than columns, including zero columns.
    set_config(1'b1, 3, 2);
    add_entry(32'h7FFF_FFFF, 1'b1, 1'b1);
    drain();
    set_config(1'b0, 2, 0);
    add_entry(32'h8000_0000, 1'b0, 1'b1);
    drain();

    // A row with every edge forbidden.
    set_config(1'b0, 2, 3);
    add_entry(32'd7, 1'b0, 1'b0);
    add_entry(32'd1, 1'b1, 1'b0);
    add_entry(32'd3, 1'b0, 1'b0);
    add_entry(32'd2, 1'b1, 1'b0);
    add_entry(32'd2, 1'b1, 1'b0);
    add_entry(32'd2, 1'b1, 1'b1);
    drain();

    // Both rows allow only the first column, so a forbidden edge is chosen.
    set_config(1'b0, 2, 2);
    add_entry(32'd0, 1'b0, 1'b0);
    add_entry(32'd5, 1'b1, 1'b0);
    add_entry(32'd5, 1'b0, 1'b0);
    add_entry(32'd9, 1'b1, 1'b1);
    drain();

    // Cost extremes in both modes.
    for (k = 0; k < 2; k++) begin
      set_config(k[0], 1, 2);
      add_entry(32'h8000_0000, 1'b0, 1'b0);
      add_entry(32'h7FFF_FFFF, 1'b0, 1'b1);
      drain();
    end

    // Ties everywhere.
    set_config(1'b0, 2, 2);
    for (k = 0; k < 4; k++) add_entry(32'd4, 1'b0, k == 3);
    drain();

    // Oversized and full-size counts use the full matrix; an early last entry solves it.
    set_config(1'b1, 31, 31);
    add_entry($urandom, 1'b0, 1'b1);
    drain();
    set_config(1'b0, 16, 16);
    add_entry($urandom, 1'b0, 1'b1);
    drain();

    // Random phases: mostly small well-formed matrices, some broken or large.
    phase = 0;
    while (entries_queued < 500) begin
      quiet = (entries_queued > 430);
      roll = $urandom_range(0, 19);
      if (roll == 0) begin
        n = $urandom_range(2, 16);
        m = $urandom_range(0, n - 1);
      end else if (roll == 1) begin
        n = 0;
        m = $urandom_range(0, 16);
      end else if (roll == 2) begin
        n = $urandom_range(8, 16);
        m = $urandom_range(n, 16);
      end else begin
        n = $urandom_range(1, 5);
        m = $urandom_range(n, 7);
      end
      set_config($urandom_range(0, 1), n, m);
      nmat = (phase == 3) ? 6 : $urandom_range(1, 5);
      if (phase == 3) hold_req++;
      for (k = 0; k < nmat; k++) begin
        count = (n * m == 0) ? 1 : n * m;
        if (roll == 2) count = $urandom_range(1, 4);
        else if ($urandom_range(0, 9) == 0) count = $urandom_range(1, count);
        queue_matrix(count, $urandom_range(0, 2), $urandom_range(0, 2) * 5);
      end
      drain();
      phase++;
    end

    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && pending_matches.size() == 0) begin
      $display("tb_rectangular_assignment_solver: PASS");
    end else begin
      $display("tb_rectangular_assignment_solver: FAIL");
    end
    $finish;
  end
endmodule
